@@ rtl/core/ttws_pkg.sv @@
// Package for the triggered tick window statistics block.
// Constants, state encoding and shared struct types; no dependencies.
package ttws_pkg;

  localparam int unsigned MAX_WINDOW    = 65535;
  localparam int unsigned DURATION_BITS = 32;

  localparam int unsigned DUR_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DUR_W-1:0] DUR_MASK =
    (DURATION_BITS >= DUR_W) ? {DUR_W{1'b1}} : DUR_W'((64'(1) << DURATION_BITS) - 64'(1));

  localparam logic [COUNT_W-1:0] WINDOW_CAP =
    (MAX_WINDOW >= (1 << COUNT_W)) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_WINDOW);

  localparam logic REG_WIN_LEN        = 1'b0;
  localparam logic REG_SLOW_THRESHOLD = 1'b1;

  localparam logic KIND_TRIGGER = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_MIN,
    S_MAX,
    S_SLOW,
    S_SUM,
    S_CHECK,
    S_DIV
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] win_len;
    logic [DUR_W-1:0]   slow_threshold_us;
  } cfg_t;

endpackage

@@ rtl/core/ttws_in_if.sv @@
// Input channel: one word is a trigger or a completed tick.
// Depends on ttws_pkg for field widths.
interface ttws_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ttws_pkg::DUR_W-1:0]  duration_us;

  modport source (output valid, kind, duration_us, input ready);
  modport sink   (input valid, kind, duration_us, output ready);
endinterface

@@ rtl/core/ttws_out_if.sv @@
// Output channel: one word is a trigger answer or a window report.
// Depends on ttws_pkg for field widths.
interface ttws_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [ttws_pkg::HANDLE_W-1:0] handle;
  logic [ttws_pkg::COUNT_W-1:0]  tick_count;
  logic [ttws_pkg::DUR_W-1:0]    min_us;
  logic [ttws_pkg::DUR_W-1:0]    max_us;
  logic [ttws_pkg::DUR_W-1:0]    avg_us;
  logic [ttws_pkg::COUNT_W-1:0]  slow_count;

  modport source (output valid, result_kind, handle, tick_count, min_us, max_us, avg_us,
                  slow_count, input ready);
  modport sink   (input valid, result_kind, handle, tick_count, min_us, max_us, avg_us,
                  slow_count, output ready);
endinterface

@@ rtl/core/ttws_regs.sv @@
// APB configuration registers: window length and slow threshold.
// Depends on ttws_pkg.
module ttws_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttws_pkg::ADDR_W-1:0]  paddr,
  input  logic [ttws_pkg::DATA_W-1:0]  pwdata,
  output logic [ttws_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ttws_pkg::cfg_t               cfg
);
  import ttws_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WIN_LEN:        cfg.win_len           <= pwdata[COUNT_W-1:0];
        REG_SLOW_THRESHOLD: cfg.slow_threshold_us <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIN_LEN:        prdata = DATA_W'(cfg.win_len);
      REG_SLOW_THRESHOLD: prdata = DATA_W'(cfg.slow_threshold_us);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/ttws_alu.sv @@
// Shared add/subtract unit; the top bit is carry out or borrow.
// Depends on ttws_pkg.
module ttws_alu (
  input  ttws_pkg::alu_req_t        req,
  output logic [ttws_pkg::SUM_W:0]  res
);
  import ttws_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default: res = '0;
    endcase
  end

endmodule

@@ rtl/core/triggered_tick_window_statistics.sv @@
// Top level: sequencer, statistics registers and restoring divider around ttws_alu.
// Depends on ttws_pkg, ttws_in_if, ttws_out_if, ttws_regs and ttws_alu.
//
// Usage. Words arrive on item (kind 0 = trigger, 1 = tick with duration_us) and
// answers leave on result. Both are valid/ready channels; a word moves when both
// are high. The user must write registers over the APB port only while the block
// is idle; the block itself does not enforce this. One word is handled at a time:
// item.ready is high only while idle. A refused trigger is answered from idle; an
// accepted one passes through S_TRIG, which takes a new handle. A tick steps
// through min, max, slow test, sum and window-end test, each using the shared
// adder in turn; a tick with no open window is dropped. The tick that ends a
// window then runs a restoring division on the same adder, one quotient bit per
// cycle, before the report is offered. The answer is held in place while
// result.ready is low; no new word is taken until it has gone. Reset clears the
// registers, closes any window and restarts handle numbering at 1.
module triggered_tick_window_statistics (
  input  logic                         clk,
  input  logic                         rst,
  ttws_in_if.sink                      item,
  ttws_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttws_pkg::ADDR_W-1:0]  paddr,
  input  logic [ttws_pkg::DATA_W-1:0]  pwdata,
  output logic [ttws_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ttws_pkg::*;

  cfg_t                 cfg;
  alu_req_t             alu_req;
  logic [SUM_W:0]       alu_res;
  logic                 borrow;

  state_t               state;
  state_t               state_next;
  logic                 out_pending;

  logic                 window_open;
  logic [HANDLE_W-1:0]  current_handle;
  logic [HANDLE_W-1:0]  last_handle;
  logic [HANDLE_W-1:0]  new_handle;
  logic [COUNT_W-1:0]   ticks_seen;
  logic [DUR_W-1:0]     running_min;
  logic [DUR_W-1:0]     running_max;
  logic [SUM_W-1:0]     running_sum;
  logic [COUNT_W-1:0]   slow_ticks;
  logic [DUR_W-1:0]     dur;

  logic                 res_kind;
  logic [HANDLE_W-1:0]  res_handle;

  logic [COUNT_W-1:0]   rem;
  logic [SUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [COUNT_W:0]     trial;

  logic [COUNT_W-1:0]   eff_window;
  logic                 take;
  logic                 refuse;

  ttws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttws_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign borrow     = alu_res[SUM_W];
  assign trial      = {rem, quo[SUM_W-1]};
  assign eff_window = (cfg.win_len > WINDOW_CAP) ? WINDOW_CAP : cfg.win_len;
  assign take       = item.valid && item.ready;
  assign refuse     = window_open || (cfg.win_len == '0);
  assign new_handle = (alu_res[HANDLE_W-1:0] == '0) ? HANDLE_W'(1) : alu_res[HANDLE_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (out_pending) begin
          if (result.ready) state_next = S_IDLE;
        end else if (take) begin
          if (item.kind == KIND_TRIGGER) begin
            state_next = refuse ? S_IDLE : S_TRIG;
          end else if (window_open) begin
            state_next = S_MIN;
          end
        end
      end
      S_TRIG:  state_next = S_IDLE;
      S_MIN:   state_next = S_MAX;
      S_MAX:   state_next = S_SLOW;
      S_SLOW:  state_next = S_SUM;
      S_SUM:   state_next = S_CHECK;
      S_CHECK: state_next = borrow ? S_IDLE : S_DIV;
      S_DIV: begin
        if (div_cnt == '0) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // adder operands and handshake outputs
  always_comb begin
    alu_req = '{op: ALU_SUB, a: '0, b: '0};
    case (state)
      S_TRIG:  alu_req = '{op: ALU_ADD, a: SUM_W'(last_handle), b: SUM_W'(1)};
      S_MIN:   alu_req = '{op: ALU_SUB, a: SUM_W'(dur), b: SUM_W'(running_min)};
      S_MAX:   alu_req = '{op: ALU_SUB, a: SUM_W'(running_max), b: SUM_W'(dur)};
      S_SLOW:  alu_req = '{op: ALU_SUB, a: SUM_W'(cfg.slow_threshold_us), b: SUM_W'(dur)};
      S_SUM:   alu_req = '{op: ALU_ADD, a: running_sum, b: SUM_W'(dur)};
      S_CHECK: alu_req = '{op: ALU_SUB, a: SUM_W'(ticks_seen), b: SUM_W'(eff_window)};
      S_DIV:   alu_req = '{op: ALU_SUB, a: SUM_W'(trial), b: SUM_W'(ticks_seen)};
      default: ;
    endcase
  end

  assign item.ready = (state == S_IDLE) && !out_pending;

  assign result.valid       = out_pending;
  assign result.result_kind = res_kind;
  assign result.handle      = res_handle;
  assign result.tick_count  = res_kind ? ticks_seen : '0;
  assign result.min_us      = res_kind ? running_min : '0;
  assign result.max_us      = res_kind ? running_max : '0;
  assign result.avg_us      = res_kind ? quo[DUR_W-1:0] : '0;
  assign result.slow_count  = res_kind ? slow_ticks : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_pending    <= 1'b0;
      window_open    <= 1'b0;
      current_handle <= '0;
      last_handle    <= '0;
      ticks_seen     <= '0;
      running_min    <= '1;
      running_max    <= '0;
      running_sum    <= '0;
      slow_ticks     <= '0;
      res_kind       <= KIND_TRIGGER;
      res_handle     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (out_pending) begin
            if (result.ready) begin
              out_pending <= 1'b0;
              if (res_kind == KIND_TICK) begin
                window_open    <= 1'b0;
                current_handle <= '0;
              end
            end
          end else if (take) begin
            if (item.kind == KIND_TRIGGER) begin
              if (refuse) begin
                out_pending <= 1'b1;
                res_kind    <= KIND_TRIGGER;
                res_handle  <= '0;
              end
            end else begin
              dur <= item.duration_us & DUR_MASK;
            end
          end
        end
        S_TRIG: begin
          last_handle    <= new_handle;
          current_handle <= new_handle;
          window_open    <= 1'b1;
          ticks_seen     <= '0;
          running_min    <= '1;
          running_max    <= '0;
          running_sum    <= '0;
          slow_ticks     <= '0;
          out_pending    <= 1'b1;
          res_kind       <= KIND_TRIGGER;
          res_handle     <= new_handle;
        end
        S_MIN: begin
          if (borrow) running_min <= dur;
        end
        S_MAX: begin
          if (borrow) running_max <= dur;
        end
        S_SLOW: begin
          if (ticks_seen != '1) ticks_seen <= ticks_seen + COUNT_W'(1);
          if (borrow && slow_ticks != '1) slow_ticks <= slow_ticks + COUNT_W'(1);
        end
        S_SUM: begin
          running_sum <= alu_res[SUM_W-1:0];
        end
        S_CHECK: begin
          rem     <= '0;
          quo     <= running_sum;
          div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        S_DIV: begin
          rem     <= borrow ? trial[COUNT_W-1:0] : alu_res[COUNT_W-1:0];
          quo     <= {quo[SUM_W-2:0], ~borrow};
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == '0) begin
            out_pending <= 1'b1;
            res_kind    <= KIND_TICK;
            res_handle  <= current_handle;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    out_pending |-> !item.ready)
    else $error("input taken while an answer is pending");

  a_open_has_handle: assert property (@(posedge clk) disable iff (rst)
    window_open |-> current_handle != '0)
    else $error("open window without a handle");

  a_report_handle: assert property (@(posedge clk) disable iff (rst)
    (out_pending && res_kind == KIND_TICK) |-> (res_handle != '0 && window_open))
    else $error("report for a window that is not open");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (ticks_seen != '0 && window_open))
    else $error("division started with zero tick count");

endmodule

@@ verif/ttws_stats_check.sv @@
`timescale 1ns / 100ps
// Scoreboard for triggered_tick_window_statistics: follows register writes on the APB
// port, predicts each trigger answer and window report from the words taken in, and
// compares every word given out. Depends on ttws_pkg, ttws_in_if and ttws_out_if.
module ttws_stats_check
  import ttws_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ttws_in_if                item,
  ttws_out_if               result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fault_count,
  output int                pending,
  output int                report_count,
  output int                refusal_count
);

  localparam logic RES_ANSWER = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef struct packed {
    logic                result_kind;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  tick_count;
    logic [DUR_W-1:0]    min_us;
    logic [DUR_W-1:0]    max_us;
    logic [DUR_W-1:0]    avg_us;
    logic [COUNT_W-1:0]  slow_count;
  } answer_t;

  answer_t due_answers[$];

  logic [COUNT_W-1:0]  cfg_window;
  logic [DUR_W-1:0]    cfg_slow;
  logic                win_open;
  logic [HANDLE_W-1:0] cur_handle;
  logic [HANDLE_W-1:0] last_handle;
  logic [COUNT_W-1:0]  ticks_seen;
  logic [DUR_W-1:0]    run_min;
  logic [DUR_W-1:0]    run_max;
  logic [SUM_W-1:0]    run_sum;
  logic [COUNT_W-1:0]  slow_ticks;
  int                  faults;
  int                  reports;
  int                  refusals;

  function automatic string show(answer_t a);
    return $sformatf("kind=%0d handle=%0d ticks=%0d min=%0d max=%0d avg=%0d slow=%0d",
                     a.result_kind, a.handle, a.tick_count, a.min_us, a.max_us, a.avg_us,
                     a.slow_count);
  endfunction

  task automatic clear_window_stats();
    ticks_seen = '0;
    run_min    = '1;
    run_max    = '0;
    run_sum    = '0;
    slow_ticks = '0;
  endtask

  task automatic advance_window(input logic kind, input logic [DUR_W-1:0] raw);
    logic [DUR_W-1:0]   dur;
    logic [COUNT_W-1:0] span;
    answer_t            a;
    dur = raw & DUR_MASK;
    a   = '0;
    if (kind == KIND_TRIGGER) begin
      a.result_kind = RES_ANSWER;
      if (!win_open && cfg_window != '0) begin
        last_handle = last_handle + 1'b1;
        if (last_handle == '0) last_handle = 1;
        cur_handle = last_handle;
        win_open   = 1'b1;
        clear_window_stats();
        a.handle = cur_handle;
      end else begin
        refusals++;
      end
      due_answers = {due_answers, a};
    end else if (win_open) begin
      if (ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
      if (dur < run_min) run_min = dur;
      if (dur > run_max) run_max = dur;
      run_sum = run_sum + SUM_W'(dur);
      if (dur > cfg_slow && slow_ticks != '1) slow_ticks = slow_ticks + 1'b1;
      span = (cfg_window > WINDOW_CAP) ? WINDOW_CAP : cfg_window;
      if (ticks_seen >= span) begin
        a.result_kind = RES_REPORT;
        a.handle      = cur_handle;
        a.tick_count  = ticks_seen;
        a.min_us      = run_min;
        a.max_us      = run_max;
        a.avg_us      = DUR_W'(run_sum / SUM_W'(ticks_seen));
        a.slow_count  = slow_ticks;
        due_answers = {due_answers, a};
        reports++;
        win_open   = 1'b0;
        cur_handle = '0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (rst) begin
      due_answers.delete();
      cfg_window  = '0;
      cfg_slow    = '0;
      win_open    = 1'b0;
      cur_handle  = '0;
      last_handle = '0;
      clear_window_stats();
      faults   = 0;
      reports  = 0;
      refusals = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = {result.result_kind, result.handle, result.tick_count, result.min_us,
               result.max_us, result.avg_us, result.slow_count};
        if (due_answers.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected word out: %s", show(got));
        end else begin
          want = due_answers.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= 10) begin
              $display("mismatch: expected %s", show(want));
              $display("          actual   %s", show(got));
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_WIN_LEN:        cfg_window = pwdata[COUNT_W-1:0];
          REG_SLOW_THRESHOLD: cfg_slow   = pwdata[DUR_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) advance_window(item.kind, item.duration_us);
    end
    fault_count   <= faults;
    pending       <= due_answers.size();
    report_count  <= reports;
    refusal_count <= refusals;
  end

endmodule

@@ verif/triggered_tick_window_statistics_test.sv @@
`timescale 1ns / 100ps
// Testbench top for triggered_tick_window_statistics: drives triggers and ticks in bursts,
// reprograms the window between phases and gives the verdict. Depends on ttws_pkg, the
// channel interfaces, the block itself and ttws_stats_check.
module triggered_tick_window_statistics_test;
  import ttws_pkg::*;

  localparam int unsigned ITEMS    = 1775;
  localparam int unsigned LIMIT    = 1_000_000;
  localparam int unsigned HOLD_OFF = 400;
  localparam int unsigned SETTLE   = 12;
  localparam int unsigned TAIL     = 64;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                fault_count;
  int                pending;
  int                report_count;
  int                refusal_count;
  int unsigned       sent       = 0;
  int unsigned       burst_left = 0;
  int unsigned       settings   = 0;
  logic [COUNT_W-1:0] win;
  logic [DUR_W-1:0]   thr;

  ttws_in_if  tick_in();
  ttws_out_if stats_out();

  triggered_tick_window_statistics u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (tick_in),
    .result  (stats_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ttws_stats_check u_check (
    .clk           (clk),
    .rst           (rst),
    .item          (tick_in),
    .result        (stats_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fault_count   (fault_count),
    .pending       (pending),
    .report_count  (report_count),
    .refusal_count (refusal_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        tick_in.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send(input logic kind, input logic [DUR_W-1:0] dur);
    tick_in.valid       <= 1'b1;
    tick_in.kind        <= kind;
    tick_in.duration_us <= dur;
    do @(posedge clk); while (!tick_in.ready);
    sent++;
    pace();
  endtask

  // idle the feed, wait for the last word out, then let a tick that gives no report finish
  task automatic settle();
    if (tick_in.valid) tick_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_dur(input logic [DUR_W-1:0] t);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return t;
      3:       return t + 1'b1;
      4:       return t - 1'b1;
      5, 6:    return DUR_W'($urandom_range(0, 5000));
      default: return DUR_W'($urandom());
    endcase
  endfunction

  initial begin : drain
    int unsigned mode;
    int unsigned stretch;
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    stats_out.ready <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(5, 200);
      repeat (stretch) begin
        @(posedge clk);
        if (stats_out.valid && stats_out.ready) taken++;
        if (!held && taken >= 120 && tick_in.valid) begin
          // long back-pressure: the block fills and stops taking words
          held = 1'b1;
          stats_out.ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
        end
        case (mode)
          0:       stats_out.ready <= 1'b1;
          1:       stats_out.ready <= 1'($urandom_range(0, 1));
          2:       stats_out.ready <= ($urandom_range(0, 3) == 0);
          default: stats_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_seq;
    int unsigned n;
    int unsigned r;
    rst                 <= 1'b1;
    tick_in.valid       <= 1'b0;
    tick_in.kind        <= KIND_TRIGGER;
    tick_in.duration_us <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero window refuses; tick with no window is dropped
    send(KIND_TRIGGER, '1);
    send(KIND_TICK, '1);

    settle();
    write_reg(REG_WIN_LEN, 32'd3);
    write_reg(REG_SLOW_THRESHOLD, 32'h7FFF_FFFF);
    settle();
    send(KIND_TRIGGER, '0);
    send(KIND_TRIGGER, '0);
    send(KIND_TICK, '0);
    send(KIND_TICK, '1);
    send(KIND_TICK, 32'h8000_0000);

    settle();
    write_reg(REG_WIN_LEN, 32'd1);
    write_reg(REG_SLOW_THRESHOLD, 32'd0);
    settle();
    send(KIND_TRIGGER, '0);
    send(KIND_TICK, '0);
    send(KIND_TRIGGER, '0);
    send(KIND_TICK, 32'd1);

    // widest window, then shortened below the ticks already seen
    settle();
    write_reg(REG_WIN_LEN, 32'hFFFF);
    write_reg(REG_SLOW_THRESHOLD, '1);
    settle();
    send(KIND_TRIGGER, '0);
    repeat (5) send(KIND_TICK, DUR_W'($urandom()));
    settle();
    write_reg(REG_WIN_LEN, 32'd2);
    settle();
    send(KIND_TICK, '1);

    // window cut to zero while open closes on the next tick
    settle();
    write_reg(REG_WIN_LEN, 32'd4);
    settle();
    send(KIND_TRIGGER, '0);
    send(KIND_TICK, 32'd7);
    settle();
    write_reg(REG_WIN_LEN, 32'd0);
    settle();
    send(KIND_TICK, 32'd9);
    send(KIND_TRIGGER, '0);
    settings = 5;

    thr = '0;
    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5)       win = '0;
      else if (r < 10) win = '1;
      else if (r < 16) win = COUNT_W'($urandom_range(40, 300));
      else             win = COUNT_W'($urandom_range(1, 12));
      settle();
      write_reg(REG_WIN_LEN, DATA_W'(win));
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        if (r == 0)      thr = '0;
        else if (r == 1) thr = '1;
        else if (r < 6)  thr = DUR_W'($urandom_range(0, 1000));
        else             thr = DUR_W'($urandom());
        write_reg(REG_SLOW_THRESHOLD, thr);
      end
      settle();
      settings++;
      n_seq = $urandom_range(1, 6);
      repeat (n_seq) begin
        if (sent >= ITEMS) break;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send(KIND_TICK, pick_dur(thr));
        end
        send(KIND_TRIGGER, DUR_W'($urandom()));
        if (win == '1)                     n = $urandom_range(1, 10);
        else if (win == '0)                n = $urandom_range(0, 2);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, win);
        else                               n = win;
        repeat (n) begin
          if (sent >= ITEMS) break;
          if ($urandom_range(0, 19) == 0) send(KIND_TRIGGER, DUR_W'($urandom()));
          send(KIND_TICK, pick_dur(thr));
        end
      end
    end

    settle();
    repeat (TAIL) @(posedge clk);
    $display("run: %0d words in over %0d register settings, %0d window reports",
             sent, settings, report_count);
    $display("run: %0d triggers refused, %0d mismatches", refusal_count, fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
